[rtl/ffha_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the first-fit heap allocator
// no dependencies; imported by the interfaces and every module

package ffha_pkg;

  localparam int MAX_BLOCKS  = 16;
  localparam int ADDR_W      = 24;
  localparam int BRK_W       = 25;
  localparam int CNT_W       = 5;
  localparam int NEED_W      = 26;
  localparam int MIN_ALLOC   = 16;
  localparam int ALLOC_ALIGN = 8;

  localparam logic [BRK_W-1:0] ADDR_SPAN   = BRK_W'(1) << ADDR_W;
  localparam logic [BRK_W-1:0] LIMIT_RESET = BRK_W'(1) << ADDR_W;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NULL    = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_IDLE,
    CELL_MATCH_FIT,
    CELL_MATCH_ADDR,
    CELL_TAKE,
    CELL_RELEASE,
    CELL_APPEND
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [BRK_W-1:0]  size;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  count;
    logic [BRK_W-1:0]  brk;
  } cell_bcast_t;

  typedef struct packed {
    logic              found;
    logic              at_tail;
    logic [ADDR_W-1:0] uaddr;
  } hit_chain_t;

  typedef struct packed {
    logic             live;
    logic [CNT_W-1:0] count;
    logic [BRK_W-1:0] brk_end;
  } tail_chain_t;

endpackage

[rtl/ffha_if.sv]
`timescale 1ns / 1ps
// valid/ready channel interfaces: request, result and heap limit write
// depends on ffha_pkg

interface ffha_req_if import ffha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ADDR_W-1:0] request_size;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, req_type, request_size, free_address, input ready);
  modport sink   (input valid, req_type, request_size, free_address, output ready);
endinterface

interface ffha_res_if import ffha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] user_address;
  logic [1:0]        status;
  logic [BRK_W-1:0]  heap_end;
  logic [CNT_W-1:0]  blocks_in_use;

  modport source (output valid, user_address, status, heap_end, blocks_in_use, input ready);
  modport sink   (input valid, user_address, status, heap_end, blocks_in_use, output ready);
endinterface

interface ffha_cfg_if import ffha_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BRK_W-1:0] heap_limit;

  modport source (output valid, heap_limit, input ready);
  modport sink   (input valid, heap_limit, output ready);
endinterface

[rtl/first_fit_heap_allocator.sv]
`timescale 1ns / 1ps
// First-fit heap allocator over a table of up to 16 blocks held in a row of cells.
// An allocate reuses the lowest free block large enough (never split) or appends a
// block of max(16, size rounded up to 8) bytes plus the header at the break; a free of
// the last block pops all trailing free blocks and lowers the break. One request is in
// flight at a time: the result is registered after the match, decide and done states,
// with a pop state before done when a free hits the last block, and done waits while the
// result register holds a result that a stalled sink has not taken. All cells compare in
// the match state, the first hit ripples through the chain and commits in decide, and
// the trailing-free scan runs in pop. A new request is accepted the cycle after the
// previous result enters the output register, so no request is taken before the last is done.
// heap_limit may only be written while no request is in flight.
// depends on ffha_pkg, ffha_if, ffha_cell and ffha_ctrl

module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int HEADER_BYTES = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  ffha_req_if.sink   in_ch,
  ffha_res_if.source out_ch,
  ffha_cfg_if.sink   cfg_ch
);

  cell_bcast_t bc;
  hit_chain_t  hit_c  [MAX_BLOCKS+1];
  tail_chain_t tail_c [MAX_BLOCKS+1];

  assign hit_c[0]           = '0;
  assign tail_c[MAX_BLOCKS] = '0;

  ffha_ctrl #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .bc     (bc),
    .hit    (hit_c[MAX_BLOCKS]),
    .tail   (tail_c[0])
  );

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    ffha_cell #(
      .IDX          (i),
      .HEADER_BYTES (HEADER_BYTES)
    ) u_cell (
      .clk      (clk),
      .bc       (bc),
      .hit_in   (hit_c[i]),
      .hit_out  (hit_c[i+1]),
      .tail_in  (tail_c[i+1]),
      .tail_out (tail_c[i])
    );
  end

endmodule

[rtl/ffha_cell.sv]
`timescale 1ns / 1ps
// one block table entry: start, capacity, free mark and compare logic
// depends on ffha_pkg; chained by first_fit_heap_allocator

module ffha_cell import ffha_pkg::*; #(
  parameter int IDX          = 0,
  parameter int HEADER_BYTES = 24
) (
  input  logic        clk,
  input  cell_bcast_t bc,
  input  hit_chain_t  hit_in,
  output hit_chain_t  hit_out,
  input  tail_chain_t tail_in,
  output tail_chain_t tail_out
);

  localparam logic [CNT_W-1:0] IDX_C    = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(IDX + 1);
  localparam logic [BRK_W-1:0] HDR      = BRK_W'(HEADER_BYTES);

  logic [ADDR_W-1:0] start_r;
  logic [ADDR_W-1:0] cap_r;
  logic              free_r;
  logic              match_r;

  logic              in_range;
  logic              is_first;
  logic              live;
  logic [BRK_W-1:0]  uaddr_w;
  logic [BRK_W-1:0]  end_w;

  assign in_range = IDX_C < bc.count;
  assign uaddr_w  = {1'b0, start_r} + HDR;
  assign end_w    = uaddr_w + {1'b0, cap_r};
  assign is_first = match_r & ~hit_in.found;
  assign live     = in_range & ~free_r;

  // lowest matching entry claims the hit
  always_comb begin
    if (is_first) begin
      hit_out.found   = 1'b1;
      hit_out.at_tail = (IDX_NEXT == bc.count);
      hit_out.uaddr   = uaddr_w[ADDR_W-1:0];
    end else begin
      hit_out = hit_in;
    end
  end

  // highest entry still in use sets the new tail
  always_comb begin
    if (live && !tail_in.live) begin
      tail_out.live    = 1'b1;
      tail_out.count   = IDX_NEXT;
      tail_out.brk_end = end_w;
    end else begin
      tail_out = tail_in;
    end
  end

  always_ff @(posedge clk) begin
    case (bc.op)
      CELL_MATCH_FIT: begin
        match_r <= in_range & free_r & ({1'b0, cap_r} >= bc.size);
      end
      CELL_MATCH_ADDR: begin
        match_r <= in_range & (uaddr_w == {1'b0, bc.addr});
      end
      CELL_TAKE: begin
        if (is_first) free_r <= 1'b0;
      end
      CELL_RELEASE: begin
        if (is_first) free_r <= 1'b1;
      end
      CELL_APPEND: begin
        if (bc.count == IDX_C) begin
          start_r <= bc.brk[ADDR_W-1:0];
          cap_r   <= bc.size[ADDR_W-1:0];
          free_r  <= 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/ffha_ctrl.sv]
`timescale 1ns / 1ps
// request sequencer: break, block count, heap limit and result register
// depends on ffha_pkg and ffha_if; drives the row of ffha_cell

module ffha_ctrl import ffha_pkg::*; #(
  parameter int HEADER_BYTES = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  ffha_req_if.sink    in_ch,
  ffha_res_if.source  out_ch,
  ffha_cfg_if.sink    cfg_ch,
  output cell_bcast_t bc,
  input  hit_chain_t  hit,
  input  tail_chain_t tail
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_DECIDE,
    S_POP,
    S_DONE
  } state_t;

  localparam logic [BRK_W-1:0]  HDR      = BRK_W'(HEADER_BYTES);
  localparam logic [BRK_W-1:0]  ALN_MASK = BRK_W'(ALLOC_ALIGN - 1);

  state_t            state_r;
  logic              type_r;
  logic              null_r;
  logic              nospace_r;
  logic [BRK_W-1:0]  size_r;
  logic [ADDR_W-1:0] addr_r;
  logic [BRK_W-1:0]  need_r;
  logic [BRK_W-1:0]  break_r;
  logic [CNT_W-1:0]  count_r;
  logic [BRK_W-1:0]  limit_r;
  logic [ADDR_W-1:0] uaddr_r;
  status_t           status_r;

  logic              out_valid_r;
  logic [ADDR_W-1:0] out_uaddr_r;
  status_t           out_status_r;
  logic [BRK_W-1:0]  out_heap_end_r;
  logic [CNT_W-1:0]  out_blocks_r;

  logic              take_in;
  logic              out_free;
  logic [BRK_W-1:0]  bumped;
  logic [BRK_W-1:0]  size_w;
  logic [BRK_W-1:0]  eff_limit;
  logic [NEED_W-1:0] need_w;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign take_in      = in_ch.valid & in_ch.ready;
  assign out_free     = ~out_valid_r | out_ch.ready;

  assign bumped    = {1'b0, in_ch.request_size} + ALN_MASK;
  assign size_w    = (in_ch.request_size < ADDR_W'(MIN_ALLOC)) ? BRK_W'(MIN_ALLOC)
                                                               : (bumped & ~ALN_MASK);
  assign eff_limit = (limit_r > ADDR_SPAN) ? ADDR_SPAN : limit_r;
  assign need_w    = NEED_W'(break_r) + NEED_W'(HDR) + NEED_W'(size_r);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.user_address  = out_uaddr_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.heap_end      = out_heap_end_r;
  assign out_ch.blocks_in_use = out_blocks_r;

  always_comb begin
    bc.op    = CELL_IDLE;
    bc.size  = size_r;
    bc.addr  = addr_r;
    bc.count = count_r;
    bc.brk   = break_r;
    case (state_r)
      S_MATCH: begin
        bc.op = type_r ? CELL_MATCH_ADDR : CELL_MATCH_FIT;
      end
      S_DECIDE: begin
        if (!null_r) begin
          if (!type_r) begin
            if (hit.found) bc.op = CELL_TAKE;
            else if (!nospace_r) bc.op = CELL_APPEND;
          end else if (hit.found) begin
            bc.op = CELL_RELEASE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      break_r     <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) limit_r <= cfg_ch.heap_limit;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (take_in) begin
            type_r  <= in_ch.req_type;
            addr_r  <= in_ch.free_address;
            size_r  <= size_w;
            null_r  <= in_ch.req_type ? (in_ch.free_address == '0)
                                      : (in_ch.request_size == '0);
            state_r <= S_MATCH;
          end
        end
        S_MATCH: begin
          nospace_r <= (count_r >= CNT_W'(MAX_BLOCKS)) || (need_w > NEED_W'(eff_limit));
          need_r    <= need_w[BRK_W-1:0];
          state_r   <= S_DECIDE;
        end
        S_DECIDE: begin
          uaddr_r <= '0;
          state_r <= S_DONE;
          if (null_r) begin
            status_r <= ST_NULL;
          end else if (!type_r) begin
            if (hit.found) begin
              status_r <= ST_OK;
              uaddr_r  <= hit.uaddr;
            end else if (nospace_r) begin
              status_r <= ST_NOSPACE;
            end else begin
              status_r <= ST_OK;
              uaddr_r  <= break_r[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
              break_r  <= need_r;
              count_r  <= count_r + CNT_W'(1);
            end
          end else if (hit.found) begin
            status_r <= ST_OK;
            if (hit.at_tail) state_r <= S_POP;
          end else begin
            status_r <= ST_UNKNOWN;
          end
        end
        S_POP: begin
          if (tail.live) begin
            count_r <= tail.count;
            break_r <= tail.brk_end;
          end else begin
            count_r <= '0;
            break_r <= '0;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_uaddr_r    <= uaddr_r;
            out_status_r   <= status_r;
            out_heap_end_r <= break_r;
            out_blocks_r   <= count_r;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/ffha_checker.sv]
`timescale 1ns / 1ps
// port-level checks of the first-fit heap allocator and its bind
// depends on ffha_pkg and first_fit_heap_allocator

module ffha_checker import ffha_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] out_user_address,
  input logic [1:0]        out_status,
  input logic [BRK_W-1:0]  out_heap_end,
  input logic [CNT_W-1:0]  out_blocks_in_use
);

  // one transaction in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_user_address == '0))
    else $error("nonzero address on a failed request");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_blocks_in_use <= CNT_W'(MAX_BLOCKS)))
    else $error("block count above table size");

  // empty table and zero break go together
  a_empty_heap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_blocks_in_use == '0) == (out_heap_end == '0)))
    else $error("break and block count disagree");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_heap_end)))
    else $error("stalled result changed");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_user_address  (out_ch.user_address),
  .out_status        (out_ch.status),
  .out_heap_end      (out_ch.heap_end),
  .out_blocks_in_use (out_ch.blocks_in_use)
);

[tb/first_fit_heap_allocator_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for first_fit_heap_allocator: directed and random
// allocate/free traffic with a heap block-table tracker. Depends on ffha_pkg, ffha_if and first_fit_heap_allocator.

module first_fit_heap_allocator_tb import ffha_pkg::*;;

  localparam int HDR_BYTES = 24;
  localparam bit REQ_ALLOC = 1'b0;
  localparam bit REQ_FREE  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] user_address;
    logic [1:0]        status;
    logic [BRK_W-1:0]  heap_end;
    logic [CNT_W-1:0]  blocks_in_use;
  } grant_t;

  class heap_tracker;
    bit [BRK_W-1:0]  limit = LIMIT_RESET;
    bit [ADDR_W-1:0] blk_start [MAX_BLOCKS];
    bit [BRK_W-1:0]  blk_cap [MAX_BLOCKS];
    bit              blk_free [MAX_BLOCKS];
    bit [CNT_W-1:0]  blk_count = '0;
    bit [BRK_W-1:0]  brk = '0;
    grant_t          grants_due[$];
    int              mismatches = 0;

    function bit [ADDR_W-1:0] data_address(int idx);
      return ADDR_W'(BRK_W'(blk_start[idx]) + BRK_W'(HDR_BYTES));
    endfunction

    function void push_grant(bit [ADDR_W-1:0] uaddr, status_t st);
      grant_t g;
      g.user_address  = uaddr;
      g.status        = st;
      g.heap_end      = brk;
      g.blocks_in_use = blk_count;
      grants_due.push_back(g);
    endfunction

    function void do_allocate(bit [ADDR_W-1:0] size);
      bit [BRK_W-1:0]  wide;
      bit [BRK_W-1:0]  rounded;
      bit [BRK_W-1:0]  eff;
      bit [NEED_W-1:0] need;
      int              idx;
      wide = BRK_W'(size);
      if (size == '0) begin
        push_grant('0, ST_NULL);
        return;
      end
      if (wide < BRK_W'(MIN_ALLOC)) rounded = BRK_W'(MIN_ALLOC);
      else rounded = (wide + BRK_W'(ALLOC_ALIGN - 1)) & ~BRK_W'(ALLOC_ALIGN - 1);
      for (int i = 0; i < int'(blk_count); i++) begin
        if (blk_free[i] && blk_cap[i] >= rounded) begin
          blk_free[i] = 1'b0;
          push_grant(data_address(i), ST_OK);
          return;
        end
      end
      need = NEED_W'(brk) + NEED_W'(HDR_BYTES) + NEED_W'(rounded);
      eff  = (limit < ADDR_SPAN) ? limit : ADDR_SPAN;
      if (int'(blk_count) >= MAX_BLOCKS || need > NEED_W'(eff)) begin
        push_grant('0, ST_NOSPACE);
        return;
      end
      idx = int'(blk_count);
      blk_start[idx] = ADDR_W'(brk);
      blk_cap[idx]   = rounded;
      blk_free[idx]  = 1'b0;
      blk_count      = blk_count + 1'b1;
      brk            = BRK_W'(need);
      push_grant(data_address(idx), ST_OK);
    endfunction

    function void do_release(bit [ADDR_W-1:0] addr);
      int hit;
      int last;
      hit = -1;
      if (addr == '0) begin
        push_grant('0, ST_NULL);
        return;
      end
      for (int i = 0; i < int'(blk_count); i++) begin
        if (hit < 0 && data_address(i) == addr) hit = i;
      end
      if (hit < 0) begin
        push_grant('0, ST_UNKNOWN);
        return;
      end
      blk_free[hit] = 1'b1;
      if (hit + 1 == int'(blk_count)) begin
        while (blk_count > 1 && blk_free[blk_count - 1]) blk_count = blk_count - 1'b1;
        last = int'(blk_count) - 1;
        brk = BRK_W'(blk_start[last]) + BRK_W'(HDR_BYTES) + blk_cap[last];
        if (blk_count == 1 && blk_free[0]) begin
          brk       = BRK_W'(blk_start[0]);
          blk_count = '0;
        end
      end
      push_grant('0, ST_OK);
    endfunction

    function void take_request(bit kind, bit [ADDR_W-1:0] size, bit [ADDR_W-1:0] addr);
      if (kind == REQ_ALLOC) do_allocate(size);
      else do_release(addr);
    endfunction

    function void compare_field(string label, longint unsigned want, longint unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
      end
    endfunction

    function void check_grant(grant_t got);
      grant_t want;
      if (grants_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result expected none actual %h", $time, got);
        return;
      end
      want = grants_due.pop_front();
      compare_field("user_address", want.user_address, got.user_address);
      compare_field("status", want.status, got.status);
      compare_field("heap_end", want.heap_end, got.heap_end);
      compare_field("blocks_in_use", want.blocks_in_use, got.blocks_in_use);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   calm = 1'b0;

  heap_tracker tracker = new;

  ffha_req_if in_if ();
  ffha_res_if out_if ();
  ffha_cfg_if cfg_if ();

  first_fit_heap_allocator #(
    .HEADER_BYTES(HDR_BYTES)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("first_fit_heap_allocator: mismatch");
    $finish;
  end

  // result side: random stall bursts unless calm is set
  initial begin
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!calm && $urandom_range(0, 1) == 1) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    grant_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.user_address  = out_if.user_address;
      got.status        = out_if.status;
      got.heap_end      = out_if.heap_end;
      got.blocks_in_use = out_if.blocks_in_use;
      tracker.check_grant(got);
    end
  end

  task automatic issue(bit kind, bit [ADDR_W-1:0] size, bit [ADDR_W-1:0] addr);
    in_if.valid        <= 1'b1;
    in_if.req_type     <= kind;
    in_if.request_size <= size;
    in_if.free_address <= addr;
    do @(posedge clk); while (!in_if.ready);
    tracker.take_request(kind, size, addr);
  endtask

  task automatic alloc_req(bit [ADDR_W-1:0] size);
    issue(REQ_ALLOC, size, ADDR_W'($urandom));
  endtask

  task automatic free_req(bit [ADDR_W-1:0] addr);
    issue(REQ_FREE, ADDR_W'($urandom), addr);
  endtask

  task automatic gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (tracker.grants_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(bit [BRK_W-1:0] value);
    settle();
    cfg_if.valid      <= 1'b1;
    cfg_if.heap_limit <= value;
    do @(posedge clk); while (!cfg_if.ready);
    tracker.limit = value;
    cfg_if.valid <= 1'b0;
  endtask

  function automatic bit [ADDR_W-1:0] random_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return '0;
    if (pick < 60) return ADDR_W'($urandom_range(1, 64));
    if (pick < 85) return ADDR_W'($urandom_range(65, 1024));
    if (pick < 93) return ADDR_W'($urandom_range(1025, 65536));
    return ADDR_W'($urandom);
  endfunction

  function automatic bit [ADDR_W-1:0] random_free_address();
    int pick;
    bit [ADDR_W-1:0] live;
    pick = $urandom_range(0, 99);
    if (tracker.blk_count == 0) live = ADDR_W'($urandom);
    else live = tracker.data_address($urandom_range(0, int'(tracker.blk_count) - 1));
    if (pick < 80) return live;
    if (pick < 85) return '0;
    if (pick < 95) return ADDR_W'($urandom);
    return live + ADDR_W'(ALLOC_ALIGN);
  endfunction

  task automatic run_phase(int count);
    int alloc_pct;
    alloc_pct = 60;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) alloc_pct = ($urandom_range(0, 1) == 1) ? 70 : 35;
      if ($urandom_range(0, 99) < alloc_pct) alloc_req(random_size());
      else free_req(random_free_address());
      gap();
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.req_type     = REQ_ALLOC;
    in_if.request_size = '0;
    in_if.free_address = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.heap_limit  = LIMIT_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_limit(LIMIT_RESET);
    alloc_req('0);
    free_req('0);
    free_req('1);
    alloc_req(ADDR_W'(1));
    alloc_req(ADDR_W'(16));
    alloc_req(ADDR_W'(17));
    alloc_req('1);
    free_req(tracker.data_address(1));
    free_req(tracker.data_address(1));
    alloc_req(ADDR_W'(10));
    free_req(tracker.data_address(0));
    free_req(tracker.data_address(2));
    // popping the tail leaves only a free head, so the heap clears
    free_req(tracker.data_address(1));
    free_req(tracker.data_address(0));
    alloc_req(ADDR_W'(24'h800000));
    free_req(tracker.data_address(0));
    write_limit(BRK_W'(HDR_BYTES + MIN_ALLOC));
    alloc_req(ADDR_W'(16));
    alloc_req(ADDR_W'(1));
    free_req(tracker.data_address(0));
    write_limit('0);
    alloc_req(ADDR_W'(1));

    write_limit(BRK_W'($urandom_range(200, 2000)));
    run_phase(250);
    write_limit('0);
    run_phase(100);
    write_limit(BRK_W'($urandom_range(4096, 1 << 20)));
    run_phase(250);
    write_limit(LIMIT_RESET);
    run_phase(250);
    calm = 1'b1;
    run_phase(250);

    settle();
    if (tracker.mismatches == 0 && tracker.grants_due.size() == 0) begin
      $display("first_fit_heap_allocator: match");
    end else begin
      $display("first_fit_heap_allocator: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ffha_pkg.sv
rtl/ffha_if.sv
rtl/ffha_cell.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator.sv
rtl/ffha_checker.sv
tb/first_fit_heap_allocator_tb.sv
